// File: src/pyi_pkg.sv
// Shared types, constants and helpers for the pose yaw injection pipeline.
// No dependencies; used by pyi_gain_round and pose_yaw_injection.
package pyi_pkg;

   // default count of CORDIC micro-rotations
   localparam int ANGLE_ITERATIONS_DEF = 16;

   // datapath widths: matrix entries scaled by 2^14 plus growth headroom
   localparam int DW = 36;
   localparam int ZW = 34;

   // inverse CORDIC gain, Q0.30
   localparam logic [29:0] GAIN_INV = 30'd652032874;

   // radians (Q15.16) to binary angle scale, split into two 23-bit halves
   localparam logic [63:0] YAW_TO_TURN = 64'd44798133900177;
   localparam logic signed [24:0] YAW_KH = {2'b00, YAW_TO_TURN[45:23]};
   localparam logic signed [24:0] YAW_KL = {2'b00, YAW_TO_TURN[22:0]};

   localparam logic signed [23:0] Q14_MAX = 24'sd16384;
   localparam logic signed [23:0] Q14_MIN = -24'sd16384;

   // per-stage payload
   typedef struct packed {
      logic [8:0][15:0]        ent;
      logic [31:0]             px;
      logic [31:0]             py;
      logic                    zero;
      logic signed [DW-1:0]    vx;
      logic signed [DW-1:0]    vy;
      logic [31:0]             vz;
      logic signed [56:0]      yh;
      logic signed [56:0]      yl;
      logic [31:0]             meas;
      logic [2:0][DW-1:0]      a;
      logic [2:0][DW-1:0]      b;
      logic signed [ZW-1:0]    rz;
   } pipe_type;

   // stage enables for the gain unit
   typedef struct packed {
      logic s1;
      logic s2;
   } gain_en_type;

   // Q1.14 entry to datapath scale (times 2^14)
   function automatic logic signed [DW-1:0] scale(input logic [15:0] v);
      return {{(DW-30){v[15]}}, v, 14'd0};
   endfunction

   // arctangent of 2^-i in binary-angle units
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// File: src/pyi_channels.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
interface pyi_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] rot_00, rot_01, rot_02;
   logic [15:0] rot_10, rot_11, rot_12;
   logic [15:0] rot_20, rot_21, rot_22;
   logic [31:0] meas_x, meas_y, meas_yaw;

   modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, meas_x, meas_y, meas_yaw,
                   input ready);
   modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, meas_x, meas_y, meas_yaw,
                 output ready);
endinterface

interface pyi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_00, out_01, out_02;
   logic [15:0] out_10, out_11, out_12;
   logic [15:0] out_20, out_21, out_22;
   logic [31:0] pos_x, pos_y;

   modport source (output valid, out_00, out_01, out_02, out_10, out_11, out_12,
                   out_20, out_21, out_22, pos_x, pos_y,
                   input ready);
   modport sink (input valid, out_00, out_01, out_02, out_10, out_11, out_12,
                 out_20, out_21, out_22, pos_x, pos_y,
                 output ready);
endinterface

// File: src/pyi_gain_round.sv
// Two-stage CORDIC gain removal: split multiply, round to nearest, saturate to Q1.14.
// Depends on pyi_pkg.
module pyi_gain_round (
   input  logic                         clock,
   input  pyi_pkg::gain_en_type         en,
   input  logic signed [pyi_pkg::DW-1:0] value,
   output logic [15:0]                  result
);

   logic signed [17:0] hi;
   logic signed [18:0] lo;
   logic signed [30:0] gain;
   logic signed [48:0] ph_ff, ph_in;
   logic signed [49:0] pl_ff, pl_in;
   logic signed [67:0] sum;
   logic signed [23:0] rnd;
   logic [15:0]        result_ff, result_in;

   // partial products over the upper and lower halves of the value
   always_comb begin
      hi    = value[pyi_pkg::DW-1:18];
      lo    = {1'b0, value[17:0]};
      gain  = {1'b0, pyi_pkg::GAIN_INV};
      ph_in = hi * gain;
      pl_in = lo * gain;
   end

   // recombine, round and clamp
   always_comb begin
      sum = $signed({ph_ff[48], ph_ff, 18'd0}) + $signed({{18{pl_ff[49]}}, pl_ff})
            + (68'sd1 <<< 43);
      rnd = sum[67:44];
      if (rnd > pyi_pkg::Q14_MAX) begin
         result_in = pyi_pkg::Q14_MAX[15:0];
      end else if (rnd < pyi_pkg::Q14_MIN) begin
         result_in = pyi_pkg::Q14_MIN[15:0];
      end else begin
         result_in = rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      if (en.s2) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/pose_yaw_injection.sv
// Top level: replaces the heading of an orientation matrix with a measured yaw.
// Depends on pyi_pkg, pyi_channels and pyi_gain_round.
//
//   channel    direction  handshake        payload
//   req_chan   in         valid / ready    rot_00..rot_22, meas_x, meas_y, meas_yaw
//   rsp_chan   out        valid / ready    out_00..out_22, pos_x, pos_y
//
// One request per cycle unless the result side stalls; 2*ANGLE_ITERATIONS+4 register
// stages, one per CORDIC micro-rotation (vectoring, then rotation) plus prep, delta and
// two gain stages. Reset clears only the stage valid bits.
// Each stage holds while the one after it is full, so empty stages fill up behind
// a stalled result and nothing is lost or repeated.
module pose_yaw_injection #(
   parameter int ANGLE_ITERATIONS = pyi_pkg::ANGLE_ITERATIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pyi_req_if.sink    req_chan,
   pyi_rsp_if.source  rsp_chan
);

   localparam int N  = ANGLE_ITERATIONS;
   localparam int NS = 2 * N + 4;
   localparam int KD = N + 1;       // delta and rotation prep stage
   localparam int KR = N + 2;       // first rotation stage
   localparam int KG = 2 * N + 2;   // first gain stage

   logic [NS-1:0]     valid_ff, valid_in;
   logic [NS:0]       rdy;
   pyi_pkg::pipe_type st_ff [NS];
   pyi_pkg::pipe_type st_in [NS];

   // ready chain: a stage takes new data when empty or draining
   assign rdy[NS] = rsp_chan.ready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_rdy
         assign rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   endgenerate
   assign req_chan.ready = rdy[0];

   // valid bits travel with the data
   assign valid_in = {valid_ff[NS-2:0], req_chan.valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   generate
      for (k = 0; k < NS; k++) begin : g_stage
         if (k == 0) begin : g_prep
            // capture request, fold heading vector into right half plane, yaw partials
            always_comb begin
               logic signed [pyi_pkg::DW-1:0] x0, y0;
               st_in[k]        = '0;
               st_in[k].ent[0] = req_chan.rot_00;
               st_in[k].ent[1] = req_chan.rot_01;
               st_in[k].ent[2] = req_chan.rot_02;
               st_in[k].ent[3] = req_chan.rot_10;
               st_in[k].ent[4] = req_chan.rot_11;
               st_in[k].ent[5] = req_chan.rot_12;
               st_in[k].ent[6] = req_chan.rot_20;
               st_in[k].ent[7] = req_chan.rot_21;
               st_in[k].ent[8] = req_chan.rot_22;
               st_in[k].px     = req_chan.meas_x;
               st_in[k].py     = req_chan.meas_y;
               st_in[k].zero   = (req_chan.rot_00 == 16'd0) && (req_chan.rot_10 == 16'd0);
               x0 = pyi_pkg::scale(req_chan.rot_00);
               y0 = pyi_pkg::scale(req_chan.rot_10);
               if (x0[pyi_pkg::DW-1]) begin
                  st_in[k].vx = -x0;
                  st_in[k].vy = -y0;
                  st_in[k].vz = 32'h8000_0000;
               end else begin
                  st_in[k].vx = x0;
                  st_in[k].vy = y0;
                  st_in[k].vz = 32'd0;
               end
               st_in[k].yh = $signed(req_chan.meas_yaw) * pyi_pkg::YAW_KH;
               st_in[k].yl = $signed(req_chan.meas_yaw) * pyi_pkg::YAW_KL;
            end
         end else if (k <= N) begin : g_vec
            // vectoring micro-rotation k-1; first one also forms the measured angle
            localparam int I = k - 1;
            always_comb begin
               logic signed [pyi_pkg::DW-1:0] dx, dy;
               logic [63:0] yh64, yl64, s64;
               st_in[k] = st_ff[k-1];
               dx = st_ff[k-1].vy >>> I;
               dy = st_ff[k-1].vx >>> I;
               if (!st_ff[k-1].vy[pyi_pkg::DW-1]) begin
                  st_in[k].vx = st_ff[k-1].vx + dx;
                  st_in[k].vy = st_ff[k-1].vy - dy;
                  st_in[k].vz = st_ff[k-1].vz + pyi_pkg::atan_turn(5'(I));
               end else begin
                  st_in[k].vx = st_ff[k-1].vx - dx;
                  st_in[k].vy = st_ff[k-1].vy + dy;
                  st_in[k].vz = st_ff[k-1].vz - pyi_pkg::atan_turn(5'(I));
               end
               yh64 = {{7{st_ff[k-1].yh[56]}}, st_ff[k-1].yh};
               yl64 = {{7{st_ff[k-1].yl[56]}}, st_ff[k-1].yl};
               s64  = {yh64[40:0], 23'd0} + yl64 + 64'h0000_0000_8000_0000;
               if (k == 1) begin
                  st_in[k].meas = s64[63:32];
               end
            end
         end else if (k == KD) begin : g_delta
            // heading difference, quarter-turn reduction, rotation operands
            always_comb begin
               logic [31:0] cur, d;
               logic signed [pyi_pkg::DW-1:0] av, bv;
               st_in[k] = st_ff[k-1];
               cur = st_ff[k-1].zero ? 32'd0 : st_ff[k-1].vz;
               d   = st_ff[k-1].meas - cur;
               for (int j = 0; j < 3; j++) begin
                  av = pyi_pkg::scale(st_ff[k-1].ent[j]);
                  bv = pyi_pkg::scale(st_ff[k-1].ent[3+j]);
                  if (d[31] ^ d[30]) begin
                     av = -av;
                     bv = -bv;
                  end
                  st_in[k].a[j] = av;
                  st_in[k].b[j] = bv;
               end
               if (d[31] ^ d[30]) begin
                  d = d + 32'h8000_0000;
               end
               st_in[k].rz = {{(pyi_pkg::ZW-32){d[31]}}, d};
            end
         end else if (k < KG) begin : g_rot
            // rotation micro-rotation, three column pairs share one angle
            localparam int I = k - KR;
            always_comb begin
               logic signed [pyi_pkg::DW-1:0] av, bv;
               st_in[k] = st_ff[k-1];
               for (int j = 0; j < 3; j++) begin
                  av = st_ff[k-1].a[j];
                  bv = st_ff[k-1].b[j];
                  if (!st_ff[k-1].rz[pyi_pkg::ZW-1]) begin
                     st_in[k].a[j] = av - (bv >>> I);
                     st_in[k].b[j] = bv + (av >>> I);
                  end else begin
                     st_in[k].a[j] = av + (bv >>> I);
                     st_in[k].b[j] = bv - (av >>> I);
                  end
               end
               if (!st_ff[k-1].rz[pyi_pkg::ZW-1]) begin
                  st_in[k].rz = st_ff[k-1].rz
                                - $signed({2'b00, pyi_pkg::atan_turn(5'(I))});
               end else begin
                  st_in[k].rz = st_ff[k-1].rz
                                + $signed({2'b00, pyi_pkg::atan_turn(5'(I))});
               end
            end
         end else begin : g_pass
            // pass-through fields ride alongside the gain unit
            assign st_in[k] = st_ff[k-1];
         end

         always_ff @(posedge clock) begin
            if (rdy[k]) begin
               st_ff[k] <= st_in[k];
            end
         end
      end
   endgenerate

   // gain removal for rows 0 and 1
   pyi_pkg::gain_en_type gain_en;
   logic [5:0][15:0]     res;
   assign gain_en.s1 = rdy[KG];
   assign gain_en.s2 = rdy[KG+1];

   genvar j;
   generate
      for (j = 0; j < 3; j++) begin : g_gain
         pyi_gain_round u_gain_a (
            .clock  (clock),
            .en     (gain_en),
            .value  ($signed(st_ff[KG-1].a[j])),
            .result (res[j])
         );
         pyi_gain_round u_gain_b (
            .clock  (clock),
            .en     (gain_en),
            .value  ($signed(st_ff[KG-1].b[j])),
            .result (res[3+j])
         );
      end
   endgenerate

   // result channel
   assign rsp_chan.valid  = valid_ff[NS-1];
   assign rsp_chan.out_00 = res[0];
   assign rsp_chan.out_01 = res[1];
   assign rsp_chan.out_02 = res[2];
   assign rsp_chan.out_10 = res[3];
   assign rsp_chan.out_11 = res[4];
   assign rsp_chan.out_12 = res[5];
   assign rsp_chan.out_20 = st_ff[NS-1].ent[6];
   assign rsp_chan.out_21 = st_ff[NS-1].ent[7];
   assign rsp_chan.out_22 = st_ff[NS-1].ent[8];
   assign rsp_chan.pos_x  = st_ff[NS-1].px;
   assign rsp_chan.pos_y  = st_ff[NS-1].py;

endmodule

// File: test/tb_pyi_channels.sv
// Request and result record types shared by the testbench.
// Depends on nothing; the channel interfaces themselves are in src/pyi_channels.sv.
`timescale 1ns / 100ps
package tb_pyi_types;

   typedef struct {
      logic [15:0] rot [9];
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] yaw;
   } pose_req_type;

   typedef struct {
      logic [15:0] mat [9];
      logic [31:0] px;
      logic [31:0] py;
   } pose_rsp_type;

endpackage

// File: test/tb_top.sv
// Testbench for pose_yaw_injection: random and directed poses, bit-exact prediction.
// Depends on pyi_pkg, pyi_channels, the block itself and tb_pyi_types.
`timescale 1ns / 100ps
module tb_top;

   localparam int ITERS = 16;
   localparam int LAT = 2 * ITERS + 4;
   localparam longint YAW_SCALE = 64'd44798133900177;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pyi_req_if req_chan ();
   pyi_rsp_if rsp_chan ();

   pose_yaw_injection #(.ANGLE_ITERATIONS(ITERS)) i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   tb_pyi_types::pose_req_type pending_reqs [$];
   tb_pyi_types::pose_rsp_type expected_poses [$];
   int        mismatches = 0;
   longint    cycle_count = 0;
   bit        stim_done = 0;
   bit        sender_hold = 0;
   int        stall_left = 0;
   bit        long_stall_done = 0;
   int        accepted = 0;
   bit        quiet_mode = 0;

   // arctangent table in binary-angle units
   function automatic longint atan_step(int i);
      longint tbl [32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
         10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
      return tbl[i];
   endfunction

   function automatic logic [31:0] heading_turn(longint x, longint y);
      logic [31:0] z;
      longint dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 32'd0;
      x = x * 16384;
      y = y * 16384;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += 32'(atan_step(i));
         end else begin
            x -= dx; y += dy; z -= 32'(atan_step(i));
         end
      end
      return z;
   endfunction

   // drop the CORDIC gain, round to nearest, clamp to Q1.14 range
   function automatic logic [15:0] unscale(longint v);
      longint r;
      r = (v * GAIN_Q30 + (64'sd1 <<< 43)) >>> 44;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   task automatic turn_pair(input longint a, input longint b, input logic [31:0] d,
                            output logic [15:0] ra, output logic [15:0] rb);
      longint z, da, db;
      a = a * 16384;
      b = b * 16384;
      // beyond a quarter turn: flip the pair and take pi off
      if (((d + 32'h4000_0000) & 32'h8000_0000) != 0) begin
         a = -a; b = -b; d = d + 32'h8000_0000;
      end
      z = longint'($signed(d));
      for (int i = 0; i < ITERS; i++) begin
         da = b >>> i;
         db = a >>> i;
         if (z >= 0) begin
            a -= da; b += db; z -= atan_step(i);
         end else begin
            a += da; b -= db; z += atan_step(i);
         end
      end
      ra = unscale(a);
      rb = unscale(b);
   endtask

   task automatic predict_pose(input tb_pyi_types::pose_req_type r,
                               output tb_pyi_types::pose_rsp_type e);
      logic [63:0] prod;
      logic [31:0] meas_turn, delta;
      logic [15:0] ra, rb;
      prod = 64'(longint'($signed(r.yaw))) * YAW_SCALE + 64'h8000_0000;
      meas_turn = prod[63:32];
      delta = meas_turn - heading_turn(longint'($signed(r.rot[0])),
                                       longint'($signed(r.rot[3])));
      for (int j = 0; j < 3; j++) begin
         turn_pair(longint'($signed(r.rot[j])), longint'($signed(r.rot[3+j])), delta, ra, rb);
         e.mat[j] = ra;
         e.mat[3+j] = rb;
      end
      for (int j = 6; j < 9; j++) e.mat[j] = r.rot[j];
      e.px = r.mx;
      e.py = r.my;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
   endtask

   function automatic logic [15:0] rand_entry();
      case ($urandom_range(0, 9))
         0: return 16'd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         3: return 16'd0;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // clock, reset, cycle limit
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      tb_pyi_types::pose_req_type r;
      int yaws [10] = '{0, 102944, -102944, 205887, -205887, 51472, -51472,
                        32'h7fffffff, 32'h80000000, 411775};
      // directed: extremes, zero heading, negative rot_00, turns beyond a quarter
      for (int k = 0; k < 22; k++) begin
         for (int j = 0; j < 9; j++) r.rot[j] = 16'd0;
         case (k % 6)
            0: ;
            1: begin r.rot[0] = -16'sd16384; r.rot[4] = -16'sd16384; r.rot[8] = 16'd16384; end
            2: begin r.rot[0] = -16'sd16384; r.rot[3] = 16'd0; end
            3: for (int j = 0; j < 9; j++) r.rot[j] = 16'h7fff;
            4: for (int j = 0; j < 9; j++) r.rot[j] = 16'h8000;
            5: begin r.rot[0] = 16'd16384; r.rot[4] = 16'd16384; r.rot[8] = 16'd16384; end
         endcase
         r.mx = (k & 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         r.my = (k & 1) ? 32'hffff_ffff : 32'd0;
         r.yaw = yaws[k % 10];
         pending_reqs.push_back(r);
      end
      for (int n = 0; n < 1200; n++) begin
         for (int j = 0; j < 9; j++) r.rot[j] = rand_entry();
         r.mx = $urandom;
         r.my = $urandom;
         r.yaw = ($urandom_range(0, 3) == 0) ? $urandom
                 : 32'($signed($urandom_range(0, 823550)) - 411775);
         pending_reqs.push_back(r);
      end
   end

   // sender: waits for empty pipeline once, mid-run
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         {req_chan.rot_00, req_chan.rot_01, req_chan.rot_02} <= '0;
         {req_chan.rot_10, req_chan.rot_11, req_chan.rot_12} <= '0;
         {req_chan.rot_20, req_chan.rot_21, req_chan.rot_22} <= '0;
         {req_chan.meas_x, req_chan.meas_y, req_chan.meas_yaw} <= '0;
      end else begin
         tb_pyi_types::pose_req_type r;
         tb_pyi_types::pose_rsp_type e;
         bit take;
         take = !req_chan.valid || req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            accepted++;
            if (accepted == 600) sender_hold = 1;
         end
         if (sender_hold && expected_poses.size() == 0 && !req_chan.valid) sender_hold = 0;
         quiet_mode = (accepted > 200 && accepted < 400);
         if (take) begin
            if (pending_reqs.size() != 0 && !sender_hold
                && (quiet_mode || $urandom_range(0, 99) >= 8)) begin
               r = pending_reqs.pop_front();
               predict_pose(r, e);
               expected_poses.push_back(e);
               req_chan.valid <= 1'b1;
               {req_chan.rot_00, req_chan.rot_01, req_chan.rot_02} <= {r.rot[0], r.rot[1], r.rot[2]};
               {req_chan.rot_10, req_chan.rot_11, req_chan.rot_12} <= {r.rot[3], r.rot[4], r.rot[5]};
               {req_chan.rot_20, req_chan.rot_21, req_chan.rot_22} <= {r.rot[6], r.rot[7], r.rot[8]};
               req_chan.meas_x <= r.mx;
               req_chan.meas_y <= r.my;
               req_chan.meas_yaw <= r.yaw;
            end else begin
               req_chan.valid <= 1'b0;
               if (pending_reqs.size() == 0) stim_done <= 1;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (accepted >= 900 && !long_stall_done) begin
            long_stall_done <= 1;
            stall_left <= 3 * LAT;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= quiet_mode || $urandom_range(0, 99) >= 8;
         end
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         tb_pyi_types::pose_rsp_type e;
         logic [15:0] got [9];
         got = '{rsp_chan.out_00, rsp_chan.out_01, rsp_chan.out_02, rsp_chan.out_10,
                 rsp_chan.out_11, rsp_chan.out_12, rsp_chan.out_20, rsp_chan.out_21,
                 rsp_chan.out_22};
         if (expected_poses.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            e = expected_poses.pop_front();
            for (int j = 0; j < 9; j++)
               if (got[j] !== e.mat[j])
                  report_mismatch($sformatf("out_%0d%0d", j / 3, j % 3), got[j], e.mat[j]);
            if (rsp_chan.pos_x !== e.px) report_mismatch("pos_x", rsp_chan.pos_x, e.px);
            if (rsp_chan.pos_y !== e.py) report_mismatch("pos_y", rsp_chan.pos_y, e.py);
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (expected_poses.size() == 0);
      repeat (2 * LAT) @(posedge clock);
      if (mismatches == 0 && expected_poses.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
src/pyi_pkg.sv
src/pyi_channels.sv
src/pyi_gain_round.sv
src/pose_yaw_injection.sv
test/tb_pyi_channels.sv
test/tb_top.sv
